>>> sv/nonce_table_with_expiry_macros.svh
// ----------------------------------------------------------------------------
// Nonce table assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef NONCE_TABLE_WITH_EXPIRY_MACROS_SVH
`define NONCE_TABLE_WITH_EXPIRY_MACROS_SVH

// Same-cycle implication, gated by the active-low reset
`define NTE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated by the active-low reset
`define NTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/nte_pkg.sv
// ----------------------------------------------------------------------------
// nte_pkg
// Types, sizes and helpers shared by the nonce table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package nte_pkg;

    localparam int MAP_DEPTH  = 256;   // power of two: home slot is the low bits
    localparam int RING_DEPTH = 128;
    localparam int MAP_W      = $clog2(MAP_DEPTH);
    localparam int RING_W     = $clog2(RING_DEPTH);
    localparam int VAL_W      = 32;
    localparam int CNT_W      = 8;
    localparam int RWORD_W    = 2 * VAL_W + 1;   // used flag, issue time, value

    typedef logic [MAP_W-1:0]  t_midx;
    typedef logic [RING_W-1:0] t_ridx;
    typedef logic [VAL_W-1:0]  t_val;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic [1:0] {
        CMD_ISSUE = 2'd0,
        CMD_USE   = 2'd1,
        CMD_TICK  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_RING_FULL  = 3'd1,
        ST_INVALID    = 3'd2,
        ST_DUPLICATE  = 3'd3,
        ST_NOT_FOUND  = 3'd4,
        ST_TABLE_FULL = 3'd5
    } t_status;

    typedef enum logic {
        CFG_TIMEOUT  = 1'b0,
        CFG_RESERVED = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_ISSUE,
        MODE_USE,
        MODE_BUILD
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_P_RD,
        S_P_CHK,
        S_R_RD,
        S_R_CHK,
        S_E_RD,
        S_E_CHK,
        S_B_RD,
        S_B_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        t_val timeout;
        t_val reserved;
    } t_cfg;

    function automatic t_ridx ring_next(t_ridx i);
        t_ridx r;
        if (i == t_ridx'(RING_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = i + t_ridx'(1);
        end
        return r;
    endfunction

    function automatic t_midx map_next(t_midx i);
        t_midx r;
        if (i == t_midx'(MAP_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = i + t_midx'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/nte_if.sv
// ----------------------------------------------------------------------------
// nte_if
// Valid/ready channels of the nonce table: command, result and register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface nte_req_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            command;
    logic [nte_pkg::VAL_W-1:0] value;
    modport source (output valid, command, value, input ready);
    modport sink   (input valid, command, value, output ready);
endinterface

interface nte_rsp_if;
    logic                  valid;
    logic                  ready;
    logic [2:0]            status;
    logic [nte_pkg::VAL_W-1:0] issued_value;
    logic [nte_pkg::CNT_W-1:0] live_count;
    logic [nte_pkg::CNT_W-1:0] expired_count;
    modport source (output valid, status, issued_value, live_count, expired_count,
                    input ready);
    modport sink   (input valid, status, issued_value, live_count, expired_count,
                    output ready);
endinterface

interface nte_cfg_if;
    logic                  valid;
    logic                  ready;
    logic                  index;
    logic [nte_pkg::VAL_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/nte_ram.sv
// ----------------------------------------------------------------------------
// nte_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nte_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> sv/nte_ctrl.sv
// ----------------------------------------------------------------------------
// nte_ctrl
// Command sequencer: probes the slot map, walks the ring, holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module nte_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire nte_pkg::t_cfg i_cfg,
    nte_req_if.sink            i_req,
    nte_rsp_if.source          o_rsp
);

    import nte_pkg::*;

    t_state r_state, n_state;
    t_mode  r_mode,  n_mode;
    t_val   r_val,   n_val;
    t_midx  r_idx,   n_idx;
    logic [MAP_W:0] r_probe, n_probe;
    t_ridx  r_head,  n_head;
    t_ridx  r_tail,  n_tail;
    t_ridx  r_ptr,   n_ptr;
    t_cnt   r_live,  n_live;
    t_cnt   r_exp,   n_exp;
    t_val   r_clock, n_clock;
    logic   r_nonempty, n_nonempty;
    t_status r_status, n_status;
    t_val   r_issued, n_issued;
    logic   r_hvld, n_hvld;
    logic [MAP_DEPTH-1:0] r_valid;

    logic   r_ov, n_ov;
    t_status r_o_status, n_o_status;
    t_val   r_o_issued, n_o_issued;
    t_cnt   r_o_live,  n_o_live;
    t_cnt   r_o_exp,   n_o_exp;

    logic   h_we, map_clr;
    t_val   h_wdata, h_q, hd;
    logic   rg_we;
    t_ridx  rg_waddr, rg_raddr;
    logic [RWORD_W-1:0] rg_wdata, rg_q;
    logic   q_used;
    t_val   q_time, q_value;

    nte_ram #(.DEPTH(MAP_DEPTH), .WIDTH(VAL_W)) u_map (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (r_idx),
        .i_wdata (h_wdata),
        .i_raddr (r_idx),
        .o_rdata (h_q)
    );

    nte_ram #(.DEPTH(RING_DEPTH), .WIDTH(RWORD_W)) u_ring (
        .i_clk   (i_clk),
        .i_we    (rg_we),
        .i_waddr (rg_waddr),
        .i_wdata (rg_wdata),
        .i_raddr (rg_raddr),
        .o_rdata (rg_q)
    );

    assign hd      = r_hvld ? h_q : '0;
    assign q_used  = rg_q[RWORD_W-1];
    assign q_time  = rg_q[2*VAL_W-1:VAL_W];
    assign q_value = rg_q[VAL_W-1:0];
    assign rg_raddr = (r_state == S_E_RD) ? r_head : r_ptr;

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_ov;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.issued_value  = r_o_issued;
    assign o_rsp.live_count    = r_o_live;
    assign o_rsp.expired_count = r_o_exp;

    always_comb begin
        n_state = r_state;   n_mode = r_mode;     n_val = r_val;
        n_idx = r_idx;       n_probe = r_probe;   n_head = r_head;
        n_tail = r_tail;     n_ptr = r_ptr;       n_live = r_live;
        n_exp = r_exp;       n_clock = r_clock;   n_nonempty = r_nonempty;
        n_status = r_status; n_issued = r_issued; n_hvld = r_hvld;
        n_ov = r_ov && !o_rsp.ready;
        n_o_status = r_o_status; n_o_issued = r_o_issued;
        n_o_live = r_o_live;     n_o_exp = r_o_exp;
        h_we = 1'b0;  h_wdata = r_val;  map_clr = 1'b0;
        rg_we = 1'b0; rg_waddr = r_tail; rg_wdata = {1'b0, r_clock, r_val};

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_val    = i_req.value;
                    n_status = ST_OK;
                    n_issued = '0;
                    n_exp    = '0;
                    n_idx    = i_req.value[MAP_W-1:0];
                    n_probe  = '0;
                    n_state  = S_DONE;
                    case (t_cmd'(i_req.command))
                        CMD_ISSUE: begin
                            n_mode = MODE_ISSUE;
                            if (ring_next(r_tail) == r_head) begin
                                n_status = ST_RING_FULL;
                            end else if (i_req.value == '0 ||
                                         i_req.value == i_cfg.reserved) begin
                                n_status = ST_INVALID;
                            end else begin
                                n_state = S_P_RD;
                            end
                        end
                        CMD_USE: begin
                            n_mode = MODE_USE;
                            if (i_req.value == '0 || i_req.value == i_cfg.reserved) begin
                                n_status = ST_INVALID;
                            end else begin
                                n_state = S_P_RD;
                            end
                        end
                        CMD_TICK: begin
                            n_clock    = r_clock + t_val'(1);
                            n_nonempty = (r_head != r_tail);
                            n_state    = S_E_RD;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_P_RD: begin
                n_hvld  = r_valid[r_idx];
                n_state = S_P_CHK;
            end
            S_P_CHK: begin
                if (hd == r_val) begin
                    case (r_mode)
                        MODE_ISSUE: begin
                            n_status = ST_DUPLICATE;
                            n_state  = S_DONE;
                        end
                        MODE_USE: begin
                            h_we    = 1'b1;
                            h_wdata = i_cfg.reserved;
                            n_ptr   = r_head;
                            n_state = S_R_RD;
                        end
                        default: begin
                            n_ptr   = ring_next(r_ptr);
                            n_state = S_B_RD;
                        end
                    endcase
                end else if (hd == '0) begin
                    case (r_mode)
                        MODE_ISSUE: begin
                            h_we     = 1'b1;
                            rg_we    = 1'b1;
                            n_tail   = ring_next(r_tail);
                            n_live   = r_live + t_cnt'(1);
                            n_issued = r_val;
                            n_state  = S_DONE;
                        end
                        MODE_USE: begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end
                        default: begin
                            h_we    = 1'b1;
                            n_ptr   = ring_next(r_ptr);
                            n_state = S_B_RD;
                        end
                    endcase
                end else if (r_probe == (MAP_W+1)'(MAP_DEPTH - 1)) begin
                    case (r_mode)
                        MODE_ISSUE: begin
                            n_status = ST_TABLE_FULL;
                            n_state  = S_DONE;
                        end
                        MODE_USE: begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end
                        default: begin
                            n_ptr   = ring_next(r_ptr);
                            n_state = S_B_RD;
                        end
                    endcase
                end else begin
                    n_probe = r_probe + (MAP_W+1)'(1);
                    n_idx   = map_next(r_idx);
                    n_state = S_P_RD;
                end
            end
            S_R_RD: begin
                n_state = (r_ptr == r_tail) ? S_DONE : S_R_CHK;
            end
            S_R_CHK: begin
                if (q_value == r_val && !q_used) begin
                    rg_we    = 1'b1;
                    rg_waddr = r_ptr;
                    rg_wdata = {1'b1, rg_q[2*VAL_W-1:0]};
                    if (r_live != '0) begin
                        n_live = r_live - t_cnt'(1);
                    end
                    n_state = S_DONE;
                end else begin
                    n_ptr   = ring_next(r_ptr);
                    n_state = S_R_RD;
                end
            end
            S_E_RD: begin
                if (r_head != r_tail) begin
                    n_state = S_E_CHK;
                end else if (r_nonempty) begin
                    map_clr = 1'b1;
                    n_ptr   = r_head;
                    n_state = S_B_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_E_CHK: begin
                if ((r_clock - q_time) >= i_cfg.timeout) begin
                    if (!q_used && r_live != '0) begin
                        n_live = r_live - t_cnt'(1);
                    end
                    n_head  = ring_next(r_head);
                    n_exp   = r_exp + t_cnt'(1);
                    n_state = S_E_RD;
                end else begin
                    map_clr = 1'b1;
                    n_ptr   = r_head;
                    n_state = S_B_RD;
                end
            end
            S_B_RD: begin
                n_state = (r_ptr == r_tail) ? S_DONE : S_B_CHK;
            end
            S_B_CHK: begin
                if (q_used) begin
                    n_ptr   = ring_next(r_ptr);
                    n_state = S_B_RD;
                end else begin
                    n_mode  = MODE_BUILD;
                    n_val   = q_value;
                    n_idx   = q_value[MAP_W-1:0];
                    n_probe = '0;
                    n_state = S_P_RD;
                end
            end
            S_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov       = 1'b1;
                    n_o_status = r_status;
                    n_o_issued = r_issued;
                    n_o_live   = r_live;
                    n_o_exp    = r_exp;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_live  <= '0;
            r_clock <= '0;
            r_ov    <= 1'b0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_live  <= n_live;
            r_clock <= n_clock;
            r_ov    <= n_ov;
            if (map_clr) begin
                r_valid <= '0;
            end else if (h_we) begin
                r_valid[r_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_val      <= n_val;
        r_idx      <= n_idx;
        r_probe    <= n_probe;
        r_ptr      <= n_ptr;
        r_exp      <= n_exp;
        r_nonempty <= n_nonempty;
        r_status   <= n_status;
        r_issued   <= n_issued;
        r_hvld     <= n_hvld;
        r_o_status <= n_o_status;
        r_o_issued <= n_o_issued;
        r_o_live   <= n_o_live;
        r_o_exp    <= n_o_exp;
    end

endmodule

`default_nettype wire

>>> sv/nonce_table_with_expiry.sv
// ----------------------------------------------------------------------------
// nonce_table_with_expiry
// Replay-guard nonce table: linear-probed slot map plus a FIFO ring with ages.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one command per transaction: issue a candidate, use a
//   presented value, or tick time. Each command returns exactly one result
//   transaction on o_rsp (status, issued value, live and expired counts).
//   i_cfg writes timeout_ticks (index 0) or reserved_value (index 1); write
//   it only while no command is in flight. It is always ready.
//   Sequencing: commands are handled one at a time. An issue or use probe
//   visits the map slot by slot, a read state and a check state per slot,
//   up to all 256 slots; a use then walks the ring entry by entry, read
//   then check, to flag its copy. A tick pops expired entries one by one,
//   then, if the ring held entries, a rebuild walks every ring entry and
//   probes the map for each live one. Both RAM reads are registered.
//   Rejected commands skip the probe and go straight to the result state.
//   Reset: the live count, ring pointers and the tick clock clear; the slot map
//   reads empty at once through per-slot valid bits, so no clearing pass.
//   Stall: the result sits in an output register; while it waits the next
//   command is already accepted and worked on, and only its own result
//   holds until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module nonce_table_with_expiry (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    nte_req_if.sink   i_req,
    nte_rsp_if.source o_rsp,
    nte_cfg_if.sink   i_cfg
);

    import nte_pkg::*;

    // Configuration registers
    t_cfg r_cfg;

    // Register writes never stall
    assign i_cfg.ready = 1'b1;

    // Latch the addressed register on each write transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout  <= t_val'(60);
            r_cfg.reserved <= '1;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_TIMEOUT:  r_cfg.timeout  <= i_cfg.data;
                CFG_RESERVED: r_cfg.reserved <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer with slot map and ring memories
    nte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

>>> sv/nte_chk.sv
// ----------------------------------------------------------------------------
// nte_chk
// Port-level checks on the result channel of the nonce table.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nonce_table_with_expiry_macros.svh"

module nte_chk (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_valid,
    input wire logic                      i_ready,
    input wire logic [2:0]                i_status,
    input wire logic [nte_pkg::VAL_W-1:0] i_issued,
    input wire logic [nte_pkg::CNT_W-1:0] i_live,
    input wire logic [nte_pkg::CNT_W-1:0] i_expired
);

    import nte_pkg::*;

    `NTE_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_status), "result dropped while stalled")
    `NTE_ASSERT_NOW(a_issue_ok, i_clk, i_rst_n, i_valid && i_status != ST_OK, i_issued == '0, "issued value on failed command")
    `NTE_ASSERT_NOW(a_exp_ok, i_clk, i_rst_n, i_valid && i_expired != '0, i_status == ST_OK && i_issued == '0, "expiry on non-tick result")
    `NTE_ASSERT_NOW(a_live_max, i_clk, i_rst_n, i_valid, i_live < CNT_W'(RING_DEPTH), "live count beyond ring capacity")

endmodule

bind nonce_table_with_expiry nte_chk u_nte_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_rsp.valid),
    .i_ready   (o_rsp.ready),
    .i_status  (o_rsp.status),
    .i_issued  (o_rsp.issued_value),
    .i_live    (o_rsp.live_count),
    .i_expired (o_rsp.expired_count)
);

`default_nettype wire

>>> test/nte_result_checker.sv
// ----------------------------------------------------------------------------
// nte_result_checker
// Watches the nonce table channels, predicts every result and compares it.
// ----------------------------------------------------------------------------
module nte_result_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  logic            i_req_ready,
    input  logic [1:0]      i_req_command,
    input  nte_pkg::t_val   i_req_value,
    input  logic            i_rsp_valid,
    input  logic            i_rsp_ready,
    input  logic [2:0]      i_rsp_status,
    input  nte_pkg::t_val   i_rsp_issued_value,
    input  nte_pkg::t_cnt   i_rsp_live_count,
    input  nte_pkg::t_cnt   i_rsp_expired_count,
    input  logic            i_cfg_valid,
    input  logic            i_cfg_ready,
    input  logic            i_cfg_index,
    input  nte_pkg::t_val   i_cfg_data,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_result_count
);

    import nte_pkg::*;

    typedef struct packed {
        logic [2:0] status;
        t_val       issued_value;
        t_cnt       live_count;
        t_cnt       expired_count;
    } t_result;

    t_result expected_results[$];

    t_val  slot_map [MAP_DEPTH];
    t_val  ring_val [RING_DEPTH];
    t_val  ring_time[RING_DEPTH];
    logic  ring_used[RING_DEPTH];
    int    head, tail;
    int    live;
    t_val  now;
    t_val  cfg_timeout, cfg_reserved;

    // Find a free slot for v: ST_OK with slot, ST_DUPLICATE or ST_TABLE_FULL.
    function automatic t_status find_free(t_val v, output int slot);
        int idx;
        idx  = int'(v[MAP_W-1:0]);
        slot = 0;
        for (int n = 0; n < MAP_DEPTH; n++) begin
            if (slot_map[idx] == v) return ST_DUPLICATE;
            if (slot_map[idx] == '0) begin
                slot = idx;
                return ST_OK;
            end
            idx = (idx + 1) % MAP_DEPTH;
        end
        return ST_TABLE_FULL;
    endfunction

    function automatic bit find_value(t_val v, output int slot);
        int idx;
        idx  = int'(v[MAP_W-1:0]);
        slot = 0;
        for (int n = 0; n < MAP_DEPTH; n++) begin
            if (slot_map[idx] == v) begin
                slot = idx;
                return 1'b1;
            end
            if (slot_map[idx] == '0) return 1'b0;
            idx = (idx + 1) % MAP_DEPTH;
        end
        return 1'b0;
    endfunction

    function automatic t_result predict_nonce_step(logic [1:0] cmd, t_val v);
        t_result r;
        int      slot, i, fill;
        bit      nonempty;
        r = '0;
        case (cmd)
            CMD_ISSUE: begin
                fill = (tail + RING_DEPTH - head) % RING_DEPTH;
                if (fill + 1 >= RING_DEPTH) begin
                    r.status = ST_RING_FULL;
                end else if (v == '0 || v == cfg_reserved) begin
                    r.status = ST_INVALID;
                end else begin
                    r.status = find_free(v, slot);
                    if (r.status == ST_OK) begin
                        slot_map[slot]  = v;
                        ring_val[tail]  = v;
                        ring_time[tail] = now;
                        ring_used[tail] = 1'b0;
                        tail = (tail + 1) % RING_DEPTH;
                        live++;
                        r.issued_value = v;
                    end
                end
            end
            CMD_USE: begin
                if (v == '0 || v == cfg_reserved) begin
                    r.status = ST_INVALID;
                end else if (!find_value(v, slot)) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    slot_map[slot] = cfg_reserved;
                    for (i = head; i != tail; i = (i + 1) % RING_DEPTH) begin
                        if (ring_val[i] == v && !ring_used[i]) begin
                            ring_used[i] = 1'b1;
                            if (live > 0) live--;
                            break;
                        end
                    end
                end
            end
            CMD_TICK: begin
                nonempty = (head != tail);
                now = now + 1;
                while (head != tail && t_val'(now - ring_time[head]) >= cfg_timeout) begin
                    if (!ring_used[head] && live > 0) live--;
                    head = (head + 1) % RING_DEPTH;
                    r.expired_count++;
                end
                if (nonempty) begin
                    foreach (slot_map[k]) slot_map[k] = '0;
                    for (i = head; i != tail; i = (i + 1) % RING_DEPTH) begin
                        if (!ring_used[i] && find_free(ring_val[i], slot) == ST_OK)
                            slot_map[slot] = ring_val[i];
                    end
                end
            end
            default: ;
        endcase
        r.live_count = t_cnt'(live);
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            foreach (slot_map[k]) slot_map[k] = '0;
            head = 0;
            tail = 0;
            live = 0;
            now  = '0;
            cfg_timeout  = 32'd60;
            cfg_reserved = 32'hFFFF_FFFF;
            expected_results.delete();
            o_fail_count   <= 0;
            o_result_count <= 0;
        end else begin
            // Results first: a command accepted now cannot be answered this edge.
            if (i_rsp_valid && i_rsp_ready) begin
                got = {i_rsp_status, i_rsp_issued_value, i_rsp_live_count,
                       i_rsp_expired_count};
                o_result_count <= o_result_count + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got != want) begin
                        $display("%0t: mismatch expected st=%0d iss=%h live=%0d exp=%0d",
                                 $time, want.status, want.issued_value,
                                 want.live_count, want.expired_count);
                        $display("%0t:          actual   st=%0d iss=%h live=%0d exp=%0d",
                                 $time, got.status, got.issued_value,
                                 got.live_count, got.expired_count);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_TIMEOUT) cfg_timeout = i_cfg_data;
                else cfg_reserved = i_cfg_data;
            end
            if (i_req_valid && i_req_ready)
                expected_results.push_back(predict_nonce_step(i_req_command, i_req_value));
        end
    end

endmodule

>>> test/nonce_table_with_expiry_tb.sv
// ----------------------------------------------------------------------------
// nonce_table_with_expiry_tb
// Drives issue, use and tick commands with bursty timing and a stalling
// result side; the checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module nonce_table_with_expiry_tb;
    import nte_pkg::*;

    logic i_clk;
    logic i_rst_n;

    nte_req_if req_ch();
    nte_rsp_if rsp_ch();
    nte_cfg_if cfg_ch();

    int fail_count, pending, result_count;
    int sent_items;
    bit hold_off;        // long stall of the result side
    bit rsp_random_on;   // stretches with no stall when low

    // Recently issued values, reused for use commands and duplicates.
    t_val issued_pool[$];

    nonce_table_with_expiry dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    nte_result_checker checker_u (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_req_valid         (req_ch.valid),
        .i_req_ready         (req_ch.ready),
        .i_req_command       (req_ch.command),
        .i_req_value         (req_ch.value),
        .i_rsp_valid         (rsp_ch.valid),
        .i_rsp_ready         (rsp_ch.ready),
        .i_rsp_status        (rsp_ch.status),
        .i_rsp_issued_value  (rsp_ch.issued_value),
        .i_rsp_live_count    (rsp_ch.live_count),
        .i_rsp_expired_count (rsp_ch.expired_count),
        .i_cfg_valid         (cfg_ch.valid),
        .i_cfg_ready         (cfg_ch.ready),
        .i_cfg_index         (cfg_ch.index),
        .i_cfg_data          (cfg_ch.data),
        .o_fail_count        (fail_count),
        .o_pending           (pending),
        .o_result_count      (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous fixed limit: a tick rebuild over a full, crowded ring is the
    // slowest command in the worst case.
    initial begin
        #200_000_000;
        $display("FAIL nonce_table_with_expiry");
        $finish;
    end

    // Receiver: stall on its own pattern, with calm stretches and hold-offs.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) rsp_ch.ready <= 1'b0;
            else if (!rsp_random_on) rsp_ch.ready <= 1'b1;
            else rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        rsp_random_on = 1'b1;
        forever begin
            repeat ($urandom_range(50, 400)) @(posedge i_clk);
            rsp_random_on = ~rsp_random_on;
        end
    end

    // Send one command; hold valid until the handshake completes.
    task automatic send_command(t_cmd cmd, t_val v);
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.value   <= v;
        do @(posedge i_clk); while (!req_ch.ready);
        sent_items++;
        if (cmd == CMD_ISSUE && v != '0) begin
            issued_pool.push_back(v);
            if (issued_pool.size() > 64) void'(issued_pool.pop_front());
        end
    endtask

    // Drop valid and wait a random gap between bursts.
    task automatic idle_gap(int max_gap);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Write a register once the block has drained.
    task automatic write_register(t_cfg_idx idx, t_val data);
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_val pick_value();
        t_val v;
        case ($urandom_range(0, 5))
            0: v = $urandom();
            1: v = $urandom_range(1, 40);                        // crowded home slots
            2: v = (t_val'($urandom_range(0, 7)) << 8) | t_val'(8'h10);  // same home slot
            default: v = issued_pool.size() > 0
                         ? issued_pool[$urandom_range(0, issued_pool.size() - 1)]
                         : $urandom();
        endcase
        return v;
    endfunction

    task automatic random_phase(int count, int tick_weight);
        int burst, k, r;
        t_cmd cmd;
        k = 0;
        while (k < count) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && k < count; b++) begin
                r = $urandom_range(0, 99);
                if (r < tick_weight) cmd = CMD_TICK;
                else if (r < tick_weight + (100 - tick_weight) / 2) cmd = CMD_ISSUE;
                else cmd = CMD_USE;
                if ($urandom_range(0, 60) == 0) cmd = t_cmd'(2'd3);   // unknown command
                send_command(cmd, pick_value());
                k++;
            end
            idle_gap(8);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.command = CMD_ISSUE;
        req_ch.value   = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_TIMEOUT;
        cfg_ch.data    = '0;
        hold_off       = 1'b0;
        sent_items     = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: invalid values, duplicates, use, reissue, unknown, expiry.
        send_command(CMD_ISSUE, 32'h0);
        send_command(CMD_ISSUE, 32'hFFFF_FFFF);
        send_command(CMD_USE,   32'hFFFF_FFFF);
        send_command(CMD_USE,   32'h0);
        send_command(CMD_TICK,  32'h0);              // tick on an empty ring
        send_command(CMD_ISSUE, 32'h0000_0105);
        send_command(CMD_ISSUE, 32'h0000_0205);      // same home slot
        send_command(CMD_ISSUE, 32'h0000_0105);      // duplicate
        send_command(CMD_ISSUE, 32'hFFFF_FFFE);
        send_command(CMD_USE,   32'h0000_0105);
        send_command(CMD_USE,   32'h0000_0105);      // passes the tombstone, not found
        send_command(CMD_USE,   32'h0000_0205);
        send_command(CMD_ISSUE, 32'h0000_0105);      // reissue of a used value
        send_command(CMD_USE,   32'h1234_5678);
        send_command(t_cmd'(2'd3), 32'hDEAD_BEEF);
        send_command(CMD_TICK,  32'hFFFF_FFFF);

        // Timeout of one: everything expires on the next tick.
        write_register(CFG_TIMEOUT, 32'd1);
        send_command(CMD_TICK, 32'h0);
        send_command(CMD_ISSUE, 32'h0000_0077);
        send_command(CMD_TICK, 32'h0);

        // Change the marker while values are live, then use one of them.
        write_register(CFG_TIMEOUT, 32'hFFFF_FFFF);
        send_command(CMD_ISSUE, 32'h0000_0042);
        send_command(CMD_ISSUE, 32'h8000_0000);
        write_register(CFG_RESERVED, 32'h0000_0042);
        send_command(CMD_USE,   32'h0000_0042);      // now invalid
        send_command(CMD_USE,   32'h8000_0000);      // tombstone becomes 0x42
        send_command(CMD_ISSUE, 32'h0000_0142);

        // Fill the ring to ring full, with no expiry.
        for (int n = 0; n < 140; n++) send_command(CMD_ISSUE, $urandom() | 32'h1);
        send_command(CMD_TICK, 32'h0);

        // Long hold-off on the result side while the sender keeps offering.
        write_register(CFG_TIMEOUT, 32'd0);
        send_command(CMD_TICK, 32'h0);               // timeout zero: everything expires
        write_register(CFG_RESERVED, 32'hFFFF_FFFF);
        write_register(CFG_TIMEOUT, 32'd5);
        hold_off = 1'b1;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 20; n++) send_command(CMD_ISSUE, $urandom_range(1, 300));
        join

        // Random phases across several timeout and marker settings.
        random_phase(170, 15);
        write_register(CFG_TIMEOUT, 32'd60);
        random_phase(170, 8);
        write_register(CFG_RESERVED, 32'h0000_0010);
        write_register(CFG_TIMEOUT, 32'd3);
        random_phase(120, 25);

        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Run covered %0d commands and %0d results over several timeout and",
                 sent_items, result_count);
        $display("marker settings, ring full, tombstones, expiry and a long result stall.");
        if (fail_count == 0) begin
            $display("PASS nonce_table_with_expiry");
        end else begin
            $display("FAIL nonce_table_with_expiry");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/nte_pkg.sv
sv/nte_if.sv
sv/nte_ram.sv
sv/nte_ctrl.sv
sv/nonce_table_with_expiry.sv
sv/nte_chk.sv
test/nte_result_checker.sv
test/nonce_table_with_expiry_tb.sv
